// ===== hw/rtl/iuhg_pkg.sv =====
// Package with constants and register indexes for the IPv4/UDP header generator.
package iuhg_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] IP_VER_IHL = 8'h45;
  localparam logic [7:0] IP_TTL = 8'd8;
  localparam logic [7:0] IP_PROTO_UDP = 8'd17;
  localparam logic [15:0] IPV4_HDR_BYTES = 16'd20;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

  localparam logic [31:0] SRC_ADDR_RST = 32'd0;
  localparam logic [31:0] DST_ADDR_RST = 32'd0;
  localparam logic [15:0] DST_PORT_RST = 16'd8053;
  localparam logic [15:0] PORT_BASE_RST = 16'd16384;
  localparam logic [15:0] PORT_SPAN_RST = 16'd4096;

  // remainder pass over a 17-bit dividend, one bit per cycle
  localparam int MOD_W = 17;
  localparam logic [4:0] MOD_LAST = 5'(MOD_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_ADDR  = 3'd0,
    REG_DST_ADDR  = 3'd1,
    REG_DST_PORT  = 3'd2,
    REG_PORT_BASE = 3'd3,
    REG_PORT_SPAN = 3'd4
  } reg_idx_t;

endpackage

// ===== hw/rtl/ipv4_udp_header_generator.sv =====
// IPv4/UDP header generator: one 28-byte header per payload length.
//
// Input channel: in_valid/in_stall with payload_length; a transfer occurs when
// in_valid is high and in_stall is low. Output channel: out_valid/out_stall with
// header_word0..6, the big-endian header words, one result per input transfer.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; indexes 0..4
// select source address, destination address, destination port, source port
// base and source port span. Other indexes are ignored.
// An input transfer reaches out_valid through the input register and then the
// result register, with an eight-term checksum adder between them; throughput is
// one header per cycle while out_stall is low and no remainder pass runs.
// A write to the span starts a remainder pass (one bit per cycle) that rebases the
// next source port offset; in_stall and cfg_ready hold during it.
// Reset zeroes ident and off_cur, sets off_nxt to one, loads register defaults.
// On a receiver stall the result register holds and the input register fills;
// in_stall rises once both are occupied, and also during a remainder pass.
module ipv4_udp_header_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [15:0]                    payload_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    header_word0,
  output logic [31:0]                    header_word1,
  output logic [31:0]                    header_word2,
  output logic [31:0]                    header_word3,
  output logic [31:0]                    header_word4,
  output logic [31:0]                    header_word5,
  output logic [31:0]                    header_word6,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iuhg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iuhg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import iuhg_pkg::*;

  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] dst_port;
  logic [15:0] sport_base;
  logic [15:0] port_span;

  logic [15:0] ident;
  logic [15:0] off_cur;
  logic [15:0] off_nxt;

  logic        busy;
  logic [4:0]  mod_cnt;
  logic [16:0] mod_dvd;
  logic [16:0] mod_div;
  logic [16:0] mod_rem;

  logic        s1_valid;
  logic [15:0] s1_payload;
  logic [15:0] s1_ident;
  logic [15:0] s1_sport;

  logic        in_xfer;
  logic        cfg_xfer;
  logic        s2_ready;
  logic        s1_ready;

  logic [16:0] span_ext;
  logic [16:0] off_inc;
  logic [15:0] off_nxt_next;

  logic [17:0] mod_trial;
  logic [16:0] mod_rem_next;

  logic [15:0] udp_len;
  logic [15:0] tot_len;
  logic [18:0] csum_sum;
  logic [16:0] csum_fold1;
  logic [16:0] csum_fold2;
  logic [15:0] csum;

  assign s2_ready  = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = busy || !s1_ready;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = !busy;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // span of zero counts as 65536
  assign span_ext     = {port_span == 16'd0, port_span};
  assign off_inc      = {1'b0, off_nxt} + 17'd1;
  assign off_nxt_next = (off_inc == span_ext) ? 16'd0 : off_inc[15:0];

  assign mod_trial    = {mod_rem, mod_dvd[16]};
  assign mod_rem_next = (mod_trial >= {1'b0, mod_div}) ?
                        17'(mod_trial - {1'b0, mod_div}) : mod_trial[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_addr   <= SRC_ADDR_RST;
      dst_addr   <= DST_ADDR_RST;
      dst_port   <= DST_PORT_RST;
      sport_base <= PORT_BASE_RST;
      port_span  <= PORT_SPAN_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        REG_SRC_ADDR:  src_addr   <= cfg_data;
        REG_DST_ADDR:  dst_addr   <= cfg_data;
        REG_DST_PORT:  dst_port   <= cfg_data[15:0];
        REG_PORT_BASE: sport_base <= cfg_data[15:0];
        REG_PORT_SPAN: port_span  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // off_nxt is the offset that follows off_cur, kept below the span
  always_ff @(posedge clk) begin
    if (rst) begin
      ident   <= '0;
      off_cur <= '0;
      off_nxt <= 16'd1;
      busy    <= 1'b0;
      mod_cnt <= '0;
    end else begin
      if (in_xfer) begin
        ident   <= 16'(ident + 16'd1);
        off_cur <= off_nxt;
        off_nxt <= off_nxt_next;
      end
      if (cfg_xfer && cfg_index == REG_PORT_SPAN) begin
        busy    <= 1'b1;
        mod_cnt <= '0;
      end else if (busy) begin
        mod_cnt <= 5'(mod_cnt + 5'd1);
        if (mod_cnt == MOD_LAST) begin
          busy    <= 1'b0;
          off_nxt <= mod_rem_next[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_xfer && cfg_index == REG_PORT_SPAN) begin
      mod_dvd <= {1'b0, off_cur} + 17'd1;
      mod_div <= {cfg_data[15:0] == 16'd0, cfg_data[15:0]};
      mod_rem <= '0;
    end else if (busy) begin
      mod_dvd <= {mod_dvd[15:0], 1'b0};
      mod_rem <= mod_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_payload <= payload_length;
      s1_ident   <= ident;
      s1_sport   <= 16'(sport_base + off_cur);
    end
  end

  assign udp_len = 16'(s1_payload + UDP_HDR_BYTES);
  assign tot_len = 16'(udp_len + IPV4_HDR_BYTES);

  assign csum_sum = 19'({IP_VER_IHL, 8'h00}) + 19'({IP_TTL, IP_PROTO_UDP})
                  + 19'(tot_len) + 19'(s1_ident)
                  + 19'(src_addr[31:16]) + 19'(src_addr[15:0])
                  + 19'(dst_addr[31:16]) + 19'(dst_addr[15:0]);
  assign csum_fold1 = {1'b0, csum_sum[15:0]} + 17'(csum_sum[18:16]);
  assign csum_fold2 = {1'b0, csum_fold1[15:0]} + 17'(csum_fold1[16]);
  assign csum       = ~csum_fold2[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      header_word0 <= {IP_VER_IHL, 8'h00, tot_len};
      header_word1 <= {s1_ident, 16'h0000};
      header_word2 <= {IP_TTL, IP_PROTO_UDP, csum};
      header_word3 <= src_addr;
      header_word4 <= dst_addr;
      header_word5 <= {s1_sport, dst_port};
      header_word6 <= {udp_len, 16'h0000};
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    busy |-> (in_stall && !cfg_ready))
    else $error("input or config taken during remainder pass");

  a_off_in_range: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ({1'b0, off_nxt} < span_ext))
    else $error("next port offset not below span");

  a_ident_step: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (ident == 16'($past(ident) + 16'd1)))
    else $error("identification did not advance");

  a_span_starts_pass: assert property (@(posedge clk) disable iff (rst)
    (cfg_xfer && cfg_index == REG_PORT_SPAN) |=> (busy && mod_cnt == 5'd0))
    else $error("span write did not start remainder pass");

endmodule
